// ----- sv/tpm_pkg.sv -----
// tpm_pkg: shared constants, types and coefficient tables of the true-peak meter
// depends on nothing; imported by tpm_mac and true_peak_4x_oversample_meter
package tpm_pkg;

	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_SAMPLE_BITS  = 24;

	localparam int TAPS      = 48;
	localparam int HIST_LEN  = TAPS - 1;
	localparam int TAP_W     = 6;
	localparam int RING_W    = 6;
	localparam int CHAN_W    = 3;
	localparam int ACT_W     = 4;
	localparam int COEF_W    = 18;
	localparam int COEF_FRAC = 17;
	localparam int ACC_GUARD = 6;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	// register index
	localparam logic [PADDR_W-3:0] REG_ACTIVE_CHANNELS = '0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAC,
		ST_ROUND,
		ST_MAX,
		ST_OUT
	} tpm_state_t;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic             clr;
		logic             vld;
		logic             last;
		logic [TAP_W-1:0] tap;
	} mac_ctl_t;

	// phase 1 coefficients, q1.17
	function automatic logic signed [COEF_W-1:0] coef_ph1(input logic [TAP_W-1:0] k);
		logic signed [COEF_W-1:0] c;
		case (k)
			6'd0: c = -18'sd3;       6'd1: c = 18'sd17;      6'd2: c = -18'sd44;
			6'd3: c = 18'sd86;       6'd4: c = -18'sd143;    6'd5: c = 18'sd218;
			6'd6: c = -18'sd313;     6'd7: c = 18'sd428;     6'd8: c = -18'sd568;
			6'd9: c = 18'sd735;      6'd10: c = -18'sd932;   6'd11: c = 18'sd1165;
			6'd12: c = -18'sd1440;   6'd13: c = 18'sd1766;   6'd14: c = -18'sd2156;
			6'd15: c = 18'sd2631;    6'd16: c = -18'sd3220;  6'd17: c = 18'sd3973;
			6'd18: c = -18'sd4982;   6'd19: c = 18'sd6418;   6'd20: c = -18'sd8673;
			6'd21: c = 18'sd12830;   6'd22: c = -18'sd23444; 6'd23: c = 18'sd117975;
			6'd24: c = 18'sd39241;   6'd25: c = -18'sd16638; 6'd26: c = 18'sd10384;
			6'd27: c = -18'sd7403;   6'd28: c = 18'sd5630;   6'd29: c = -18'sd4438;
			6'd30: c = 18'sd3572;    6'd31: c = -18'sd2908;  6'd32: c = 18'sd2382;
			6'd33: c = -18'sd1952;   6'd34: c = 18'sd1596;   6'd35: c = -18'sd1296;
			6'd36: c = 18'sd1044;    6'd37: c = -18'sd829;   6'd38: c = 18'sd648;
			6'd39: c = -18'sd495;    6'd40: c = 18'sd368;    6'd41: c = -18'sd263;
			6'd42: c = 18'sd179;     6'd43: c = -18'sd113;   6'd44: c = 18'sd63;
			6'd45: c = -18'sd29;     6'd46: c = 18'sd9;      6'd47: c = 18'sd0;
			default: c = '0;
		endcase
		return c;
	endfunction

	// phase 2 is symmetric: only the first half is stored
	function automatic logic signed [COEF_W-1:0] coef_ph2(input logic [TAP_W-1:0] k);
		logic [TAP_W-1:0]         i;
		logic signed [COEF_W-1:0] c;
		i = (k < TAP_W'(TAPS / 2)) ? k : (TAP_W'(HIST_LEN) - k);
		case (i)
			6'd0: c = -18'sd2;       6'd1: c = 18'sd18;      6'd2: c = -18'sd51;
			6'd3: c = 18'sd105;      6'd4: c = -18'sd180;    6'd5: c = 18'sd280;
			6'd6: c = -18'sd406;     6'd7: c = 18'sd562;     6'd8: c = -18'sd751;
			6'd9: c = 18'sd976;      6'd10: c = -18'sd1244;  6'd11: c = 18'sd1560;
			6'd12: c = -18'sd1933;   6'd13: c = 18'sd2374;   6'd14: c = -18'sd2902;
			6'd15: c = 18'sd3540;    6'd16: c = -18'sd4327;  6'd17: c = 18'sd5325;
			6'd18: c = -18'sd6644;   6'd19: c = 18'sd8490;   6'd20: c = -18'sd11306;
			6'd21: c = 18'sd16246;   6'd22: c = -18'sd27547; 6'd23: c = 18'sd83354;
			default: c = '0;
		endcase
		return c;
	endfunction

	// phase 3 is phase 1 reversed
	function automatic logic signed [COEF_W-1:0] coef_ph3(input logic [TAP_W-1:0] k);
		return coef_ph1(TAP_W'(HIST_LEN) - k);
	endfunction

endpackage

// ----- sv/tpm_ram.sv -----
// tpm_ram: generic single-write, single-read memory with registered read data
// depends on nothing
module tpm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- sv/tpm_mac.sv -----
// tpm_mac: shared three-lane multiply-accumulate unit, one tap per cycle
// depends on tpm_pkg (coefficient tables, mac_ctl_t)
module tpm_mac
	import tpm_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  mac_ctl_t                                            ctl,
	input  logic signed [SAMPLE_BITS-1:0]                       din,
	output logic signed [SAMPLE_BITS+COEF_W+ACC_GUARD-1:0]      acc_ph1,
	output logic signed [SAMPLE_BITS+COEF_W+ACC_GUARD-1:0]      acc_ph2,
	output logic signed [SAMPLE_BITS+COEF_W+ACC_GUARD-1:0]      acc_ph3,
	output logic                                                done
);

	localparam int PROD_W = SAMPLE_BITS + COEF_W;
	localparam int ACC_W  = PROD_W + ACC_GUARD;

	logic signed [COEF_W-1:0] coef [3];
	logic signed [PROD_W-1:0] prod_s2 [3];
	logic signed [ACC_W-1:0]  acc_q [3];
	logic                     vld_s2;
	logic                     last_s2;
	logic                     done_q;

	always_comb begin
		coef[0] = coef_ph1(ctl.tap);
		coef[1] = coef_ph2(ctl.tap);
		coef[2] = coef_ph3(ctl.tap);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s2[i] <= din * coef[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			vld_s2  <= ctl.vld && !ctl.clr;
			last_s2 <= ctl.last;
			done_q  <= vld_s2 && last_s2 && !ctl.clr;
			for (int i = 0; i < 3; i++) begin
				if (ctl.clr) begin
					acc_q[i] <= '0;
				end else if (vld_s2) begin
					acc_q[i] <= acc_q[i] +
						{{ACC_GUARD{prod_s2[i][PROD_W-1]}}, prod_s2[i]};
				end
			end
		end
	end

	assign acc_ph1 = acc_q[0];
	assign acc_ph2 = acc_q[1];
	assign acc_ph3 = acc_q[2];
	assign done    = done_q;

endmodule

// ----- sv/true_peak_4x_oversample_meter.sv -----
// true_peak_4x_oversample_meter: top level of the 4x oversampling true-peak meter
// depends on tpm_pkg, tpm_ram (sample history) and tpm_mac (phase filters)

// One word in gives one word out. Each input word carries a sample for one of
// up to MAX_CHANNELS interleaved channels; the meter runs three 48-tap phase
// filters over that channel's last 47 samples plus the new one, takes the
// largest magnitude of the new sample and the three filtered phases as the
// sample peak (unsigned q1.23, saturating) and folds it into a running peak.
// A word with restart set reloads the running peak from peak_seed before its
// own sample is folded in. While active_channels is zero, or for a channel at
// or above active_channels, the sample is ignored: sample peak is zero and the
// history is untouched, but restart still applies. A metered word passes through
// the single shared multiply-accumulate unit stepping one tap per cycle through
// 48 taps, the multiply and accumulate pipeline registers, the registered
// finish flag of the unit and three finishing steps (round, compare, hand
// over); the next word can be taken as soon as the result appears. An
// ignored word skips the unit and the round and compare steps and goes
// straight to hand over, which waits while the result side holds off a
// waiting result. s_tready stays low while a word is being worked on. After
// reset the history memory is swept to zero, during which no word is
// accepted; register writes are taken at any time.
// active_channels should only be written while the meter is idle.
module true_peak_4x_oversample_meter
	import tpm_pkg::*;
#(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// sample, peak_seed, restart
	input  logic [((2*SAMPLE_BITS+1+7)/8)*8-1:0]   s_tdata,
	// channel
	input  logic [CHAN_W-1:0]                      s_tuser,
	// last_in_block
	input  logic                                   s_tlast,
	// result stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// sample_peak, running_peak
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
	// block_done
	output logic                                   m_tlast,
	// register port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [PADDR_W-1:0]                     paddr,
	input  logic [PDATA_W-1:0]                     pwdata,
	output logic [PDATA_W-1:0]                     prdata,
	output logic                                   pready
);

	localparam int SB      = SAMPLE_BITS;
	localparam int OUT_W   = ((2*SAMPLE_BITS+7)/8)*8;
	localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int RAM_AW  = CH_W + RING_W;
	localparam int RAM_D   = 2 ** RAM_AW;
	localparam int ACC_W   = SAMPLE_BITS + COEF_W + ACC_GUARD;
	localparam int R_W     = ACC_W - COEF_FRAC + 1;
	localparam int CMP_W   = 8;

	// magnitude of an accumulator, rounded to q1.23 and saturated
	function automatic logic [SB-1:0] to_peak(input logic signed [ACC_W-1:0] a);
		logic [ACC_W-1:0] mag;
		logic [ACC_W:0]   sum;
		logic [R_W-1:0]   r;
		mag = a[ACC_W-1] ? (~$unsigned(a) + ACC_W'(1)) : $unsigned(a);
		sum = {1'b0, mag} + ((ACC_W+1)'(1) << (COEF_FRAC - 1));
		r   = sum[ACC_W:COEF_FRAC];
		return (|r[R_W-1:SB]) ? {SB{1'b1}} : r[SB-1:0];
	endfunction

	function automatic logic [SB-1:0] umax(input logic [SB-1:0] x, input logic [SB-1:0] y);
		return (x > y) ? x : y;
	endfunction

	function automatic logic [RING_W-1:0] ring_next(input logic [RING_W-1:0] i);
		return (i == RING_W'(HIST_LEN - 1)) ? '0 : (i + RING_W'(1));
	endfunction

	tpm_state_t state_q, state_d;

	// register and handshake
	logic [ACT_W-1:0]        active_q;
	logic                    cfg_wr;
	logic                    accept;
	logic                    out_go;
	logic                    in_ok;
	logic [CMP_W-1:0]        active_eff;

	// word being worked on
	logic [CH_W-1:0]         ch_idx_q;
	logic signed [SB-1:0]    sample_q;
	logic                    last_q;
	logic [SB-1:0]           hold_q;

	// history ring pointers, one per channel, each at the oldest sample
	logic [RING_W-1:0]       ptr_q [2**CH_W];
	logic [RING_W-1:0]       rd_idx_q;
	logic [TAP_W-1:0]        iss_q;
	logic                    iss_done_q;
	logic                    issue;
	logic [TAP_W-1:0]        tap_s1;
	logic                    vld_s1;
	logic [RAM_AW-1:0]       clr_cnt_q;

	// memory port
	logic                    rd_en;
	logic                    wr_en;
	logic [RAM_AW-1:0]       wr_addr;
	logic [SB-1:0]           wr_data;
	logic [SB-1:0]           rd_data;

	// shared unit
	mac_ctl_t                mac_ctl;
	logic signed [SB-1:0]    mac_din;
	logic signed [ACC_W-1:0] acc_ph1, acc_ph2, acc_ph3;
	logic                    mac_done;

	// finishing
	logic [SB-1:0]           pk_q [4];
	logic [SB-1:0]           speak_q;
	logic [SB-1:0]           new_hold;
	logic [SB-1:0]           out_speak_q;
	logic [SB-1:0]           out_hold_q;
	logic                    out_last_q;
	logic                    m_tvalid_q;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite &&
		(paddr[PADDR_W-1:2] == REG_ACTIVE_CHANNELS);
	assign prdata = (paddr[PADDR_W-1:2] == REG_ACTIVE_CHANNELS) ?
		PDATA_W'(active_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_wr) begin
			active_q <= pwdata[ACT_W-1:0];
		end
	end

	// channel is metered only below both the register and the channel count
	assign active_eff = ({{(CMP_W-ACT_W){1'b0}}, active_q} > CMP_W'(MAX_CHANNELS)) ?
		CMP_W'(MAX_CHANNELS) : {{(CMP_W-ACT_W){1'b0}}, active_q};
	assign in_ok = ({{(CMP_W-CHAN_W){1'b0}}, s_tuser} < active_eff);

	assign accept = s_tvalid && s_tready;
	assign out_go = !m_tvalid_q || m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		issue    = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = {ch_idx_q, ptr_q[ch_idx_q]};
		wr_data  = sample_q;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = '0;
				if (clr_cnt_q == {RAM_AW{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = in_ok ? ST_MAC : ST_OUT;
				end
			end
			ST_MAC: begin
				issue = !iss_done_q;
				// the newest tap comes from the word itself, not the memory
				rd_en = issue && (iss_q != TAP_W'(HIST_LEN));
				if (mac_done) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				// new sample overwrites the oldest entry of the ring
				wr_en   = 1'b1;
				state_d = ST_MAX;
			end
			ST_MAX: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			iss_q      <= '0;
			iss_done_q <= 1'b0;
			rd_idx_q   <= '0;
			vld_s1     <= 1'b0;
			tap_s1     <= '0;
			hold_q     <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < 2**CH_W; i++) begin
				ptr_q[i] <= '0;
			end
		end else begin
			vld_s1 <= issue;
			tap_s1 <= iss_q;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + RAM_AW'(1);
			end
			if (accept) begin
				iss_q      <= '0;
				iss_done_q <= 1'b0;
				rd_idx_q   <= ptr_q[CH_W'(s_tuser)];
				if (s_tdata[2*SB]) begin
					hold_q <= s_tdata[2*SB-1:SB];
				end
			end
			if (issue) begin
				iss_q    <= iss_q + TAP_W'(1);
				rd_idx_q <= ring_next(rd_idx_q);
				if (iss_q == TAP_W'(HIST_LEN)) begin
					iss_done_q <= 1'b1;
				end
			end
			if (state_q == ST_ROUND) begin
				ptr_q[ch_idx_q] <= ring_next(ptr_q[ch_idx_q]);
			end
			if (state_q == ST_OUT && out_go) begin
				hold_q     <= new_hold;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// word and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_idx_q <= CH_W'(s_tuser);
			sample_q <= s_tdata[SB-1:0];
			last_q   <= s_tlast;
			speak_q  <= '0;
		end
		if (state_q == ST_ROUND) begin
			// phase 0 is the new sample itself
			pk_q[0] <= sample_q[SB-1] ? (~$unsigned(sample_q) + SB'(1)) : $unsigned(sample_q);
			pk_q[1] <= to_peak(acc_ph1);
			pk_q[2] <= to_peak(acc_ph2);
			pk_q[3] <= to_peak(acc_ph3);
		end
		if (state_q == ST_MAX) begin
			speak_q <= umax(umax(pk_q[0], pk_q[1]), umax(pk_q[2], pk_q[3]));
		end
		if (state_q == ST_OUT && out_go) begin
			out_speak_q <= speak_q;
			out_hold_q  <= new_hold;
			out_last_q  <= last_q;
		end
	end

	assign new_hold = umax(speak_q, hold_q);

	tpm_ram #(
		.WIDTH(SB),
		.DEPTH(RAM_D)
	) u_hist (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr({ch_idx_q, rd_idx_q}),
		.rd_data(rd_data)
	);

	// tap stage 1 lines up with the registered memory read
	assign mac_ctl.clr  = accept;
	assign mac_ctl.vld  = vld_s1;
	assign mac_ctl.last = (tap_s1 == TAP_W'(HIST_LEN));
	assign mac_ctl.tap  = tap_s1;
	assign mac_din      = (tap_s1 == TAP_W'(HIST_LEN)) ? sample_q : $signed(rd_data);

	tpm_mac #(
		.SAMPLE_BITS(SB)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.din    (mac_din),
		.acc_ph1(acc_ph1),
		.acc_ph2(acc_ph2),
		.acc_ph3(acc_ph3),
		.done   (mac_done)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({out_hold_q, out_speak_q});
	assign m_tlast  = out_last_q;

endmodule
